// File: hdl/u2a_pkg.sv
// Package for the UTF-8 Latin-1 to ASCII stream converter.
// Holds lead codes, state and result types, and the replacement tables.
// No dependencies.
`default_nettype none
package u2a_pkg;

	// Pending lead byte code
	typedef enum logic [1:0] {
		LEAD_NONE = 2'd0,
		LEAD_C3   = 2'd1,
		LEAD_C2   = 2'd2
	} lead_t;

	// Per-string state
	typedef struct packed {
		lead_t       lead;
		logic [15:0] cnt;
		logic        closed;
	} str_state_t;

	// Output word: {end_mark, out_char}
	typedef struct packed {
		logic       end_mark;
		logic [6:0] out_char;
	} out_word_t;

	// Words produced by one input byte
	typedef struct packed {
		logic [1:0] num;
		out_word_t  w0;
		out_word_t  w1;
	} step_res_t;

	localparam logic [7:0] BYTE_C3   = 8'hC3;
	localparam logic [7:0] BYTE_C2   = 8'hC2;
	localparam logic [7:0] BYTE_HIGH = 8'h80;
	localparam logic [6:0] CHR_QUEST = 7'h3F;

	// Replacement after a 0xC3 lead
	function automatic logic [6:0] map_c3(input logic [7:0] b);
		logic [6:0] c;
		case (b) inside
			[8'h80:8'h86]:        c = 7'h41; // A
			8'h87:                c = 7'h43; // C
			[8'h88:8'h8B]:        c = 7'h45; // E
			[8'h8C:8'h8F]:        c = 7'h49; // I
			8'h91:                c = 7'h4E; // N
			[8'h92:8'h96], 8'h98: c = 7'h4F; // O
			[8'h99:8'h9C]:        c = 7'h55; // U
			8'h9D:                c = 7'h59; // Y
			[8'hA0:8'hA6]:        c = 7'h61; // a
			8'hA7:                c = 7'h63; // c
			[8'hA8:8'hAB]:        c = 7'h65; // e
			[8'hAC:8'hAF]:        c = 7'h69; // i
			8'hB1:                c = 7'h6E; // n
			[8'hB2:8'hB6], 8'hB8: c = 7'h6F; // o
			[8'hB9:8'hBC]:        c = 7'h75; // u
			8'hBD, 8'hBF:         c = 7'h79; // y
			default:              c = CHR_QUEST;
		endcase
		return c;
	endfunction

	// Replacement after a 0xC2 lead
	function automatic logic [6:0] map_c2(input logic [7:0] b);
		logic [6:0] c;
		case (b)
			8'hA9:   c = 7'h43; // C
			8'hAE:   c = 7'h52; // R
			8'hB0:   c = 7'h6F; // o
			8'hB1:   c = 7'h2B; // +
			8'hB2:   c = 7'h32; // 2
			8'hB3:   c = 7'h33; // 3
			default: c = CHR_QUEST;
		endcase
		return c;
	endfunction

endpackage
`default_nettype wire

// File: hdl/u2a_step.sv
// Per-byte conversion: maps one byte against the string state and
// produces up to two output words plus the next state. Uses u2a_pkg.
`default_nettype none
module u2a_step import u2a_pkg::*; (
	input  wire logic [7:0]  in_byte,
	input  wire logic        last_byte,
	input  wire logic [15:0] capacity,
	input  wire str_state_t  cur,
	output str_state_t       nxt,
	output step_res_t        res
);

	logic        full_now;
	logic        full_after;
	logic        have_char;
	logic        term;
	logic [6:0]  ch;
	logic [15:0] cnt_inc;
	lead_t       lead_n;

	// capacity checks before and after one more character
	assign full_now   = ({1'b0, cur.cnt} + 17'd1) >= {1'b0, capacity};
	assign full_after = ({1'b0, cur.cnt} + 17'd2) >= {1'b0, capacity};
	assign cnt_inc    = cur.cnt + 16'd1;

	// character selection
	always_comb begin
		have_char = 1'b0;
		term      = 1'b0;
		ch        = '0;
		lead_n    = cur.lead;
		if (full_now) begin
			term = 1'b1;
		end else if (cur.lead != LEAD_NONE) begin
			have_char = 1'b1;
			lead_n    = LEAD_NONE;
			if (in_byte == '0) begin
				ch   = CHR_QUEST;
				term = 1'b1;
			end else if (cur.lead == LEAD_C3) begin
				ch = map_c3(in_byte);
			end else begin
				ch = map_c2(in_byte);
			end
		end else if (in_byte == '0) begin
			term = 1'b1;
		end else if (in_byte < BYTE_HIGH) begin
			ch        = in_byte[6:0];
			have_char = 1'b1;
		end else if (in_byte == BYTE_C3 || in_byte == BYTE_C2) begin
			if (last_byte) begin
				ch        = CHR_QUEST;
				have_char = 1'b1;
			end else begin
				lead_n = (in_byte == BYTE_C3) ? LEAD_C3 : LEAD_C2;
			end
		end else begin
			ch        = CHR_QUEST;
			have_char = 1'b1;
		end
		if (have_char && full_after) begin
			term = 1'b1;
		end
		if (last_byte) begin
			term = 1'b1;
		end
	end

	// output words
	always_comb begin
		res.w0 = '0;
		res.w1 = '0;
		if (cur.closed) begin
			res.num = 2'd0;
		end else if (have_char) begin
			res.w0.out_char = ch;
			res.w1.end_mark = 1'b1;
			res.num = term ? 2'd2 : 2'd1;
		end else begin
			res.w0.end_mark = 1'b1;
			res.num = term ? 2'd1 : 2'd0;
		end
	end

	// next state; last byte always starts a fresh string
	always_comb begin
		nxt = cur;
		if (last_byte) begin
			nxt.lead   = LEAD_NONE;
			nxt.cnt    = '0;
			nxt.closed = 1'b0;
		end else if (!cur.closed) begin
			nxt.lead = term ? LEAD_NONE : lead_n;
			nxt.cnt  = have_char ? cnt_inc : cur.cnt;
			if (term) begin
				nxt.closed = 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// File: hdl/utf8_latin1_to_ascii.sv
// UTF-8 (Latin-1 subset) to 7-bit ASCII stream converter, top level.
// An accepted byte's words are written into the output queue; m_tdata shows the word at the queue head.
// Throughput: one byte per cycle while s_tready is high; words drain one per cycle while m_tready
// is high, through a four-entry queue, so s_tready drops only while more than two words wait.
// Reset (arst_n low, async): string state cleared, queue empty, capacity 64.
// Depends on u2a_pkg and u2a_step.
`default_nettype none
module utf8_latin1_to_ascii import u2a_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input byte stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] in_byte
	input  wire logic        s_tlast,   // last_byte
	// output character stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata,   // [6:0] out_char, [7] zero pad
	output logic             m_tlast,   // end_mark
	// register port
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	localparam logic REG_CAPACITY = 1'b0;

	logic [15:0] capacity_q;
	str_state_t  state_q;
	str_state_t  state_n;
	step_res_t   res;
	out_word_t   queue_q [4];
	logic [1:0]  head_q;
	logic [1:0]  tail_q;
	logic [2:0]  count_q;
	logic        push;
	logic        pop;
	logic [1:0]  push_n;

	// register port
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_CAPACITY) ? {16'd0, capacity_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= 16'd64;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_CAPACITY) begin
			capacity_q <= pwdata[15:0];
		end
	end

	// byte conversion
	u2a_step u_step (
		.in_byte   (s_tdata),
		.last_byte (s_tlast),
		.capacity  (capacity_q),
		.cur       (state_q),
		.nxt       (state_n),
		.res       (res)
	);

	assign s_tready = (count_q <= 3'd2);
	assign push     = s_tvalid && s_tready;
	assign pop      = m_tvalid && m_tready;
	assign push_n   = push ? res.num : 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{lead: LEAD_NONE, cnt: '0, closed: 1'b0};
		end else if (push) begin
			state_q <= state_n;
		end
	end

	// output word queue
	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			queue_q[tail_q] <= res.w0;
		end
		if (push_n == 2'd2) begin
			queue_q[tail_q + 2'd1] <= res.w1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			tail_q  <= tail_q + push_n;
			head_q  <= head_q + {1'b0, pop};
			count_q <= count_q + {1'b0, push_n} - {2'b00, pop};
		end
	end

	assign m_tvalid = (count_q != 3'd0);
	assign m_tdata  = {1'b0, queue_q[head_q].out_char};
	assign m_tlast  = queue_q[head_q].end_mark;

	// checks
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 3'd4)
		else $error("output queue overflow");

	a_closed_no_lead: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.closed |-> state_q.lead == LEAD_NONE)
		else $error("lead held in a closed string");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tlast) |=>
		(state_q.cnt == '0 && !state_q.closed && state_q.lead == LEAD_NONE))
		else $error("string state not cleared after last byte");

endmodule
`default_nettype wire
